>>> hw/rtl/nnis_pkg.sv
// Shared constants for the nearest-neighbor image scaler.
// Holds register indexes, transaction kinds, reset values and parameter defaults.
// No dependencies.
package nnis_pkg;

   // Parameter defaults for the source store.
   localparam int SRC_MAX_W_DEFAULT = 256;
   localparam int SRC_MAX_H_DEFAULT = 256;

   // Field widths fixed by the interface.
   localparam int COORD_W = 12;
   localparam int PIXEL_W = 32;
   localparam int INDEX_W = 24;
   localparam int DSIZE_W = 13;
   localparam int SSIZE_W = 9;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 13;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_DEST_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEST_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEST_PITCH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_WIDTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd4;

   // Register reset values.
   localparam logic [DSIZE_W-1:0] DEST_WIDTH_RST = 13'd1024;
   localparam logic [DSIZE_W-1:0] DEST_HEIGHT_RST = 13'd768;
   localparam logic [DSIZE_W-1:0] DEST_PITCH_RST = 13'd1024;
   localparam logic [SSIZE_W-1:0] SOURCE_WIDTH_RST = 9'd256;
   localparam logic [SSIZE_W-1:0] SOURCE_HEIGHT_RST = 9'd256;

   // Transaction kinds.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_FETCH = 1'b1;

endpackage

>>> hw/rtl/nearest_neighbor_image_scaler.sv
// Nearest-neighbor image scaler top level: pipeline, divider stages, configuration.
// Depends on nnis_pkg and nnis_ram.
//
// Load transactions write one source pixel into an internal store of
// SRC_MAX_W x SRC_MAX_H words; loads outside the configured source size are
// dropped and return nothing. Fetch transactions return the destination index
// (row * pitch + column, low 24 bits) and the nearest source pixel, or zeros
// with out_of_range set when the coordinate lies outside the destination size.
// The block takes one transaction per clock while the result is not stalled.
// The restoring divider resolves one quotient bit per pipeline stage. Empty
// stages collapse, so a stalled result does not block acceptance until the
// pipeline is full. The pixel store is not cleared; fetching a pixel that was
// never loaded returns an arbitrary value.
module nearest_neighbor_image_scaler #(
   parameter int SRC_MAX_W = nnis_pkg::SRC_MAX_W_DEFAULT,
   parameter int SRC_MAX_H = nnis_pkg::SRC_MAX_H_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_kind,
   input  logic [nnis_pkg::COORD_W-1:0]       req_coord_x,
   input  logic [nnis_pkg::COORD_W-1:0]       req_coord_y,
   input  logic [nnis_pkg::PIXEL_W-1:0]       req_pixel_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [nnis_pkg::INDEX_W-1:0]       rsp_dest_index,
   output logic [nnis_pkg::PIXEL_W-1:0]       rsp_pixel_out,
   output logic                               rsp_out_of_range,
   input  logic                               csr_wr_en,
   input  logic [nnis_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nnis_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int QX = (SRC_MAX_W > 1) ? $clog2(SRC_MAX_W) : 1;
   localparam int QY = (SRC_MAX_H > 1) ? $clog2(SRC_MAX_H) : 1;
   localparam int Q = (QX > QY) ? QX : QY;
   localparam int CW = nnis_pkg::DSIZE_W + Q;
   localparam int SWW = $clog2(SRC_MAX_W + 1);
   localparam int SHW = $clog2(SRC_MAX_H + 1);
   localparam int DEPTH = SRC_MAX_W * SRC_MAX_H;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDXW = 2 * nnis_pkg::COORD_W + 2;
   localparam int STG_ADDR = Q + 2;
   localparam int NSTG = Q + 4;

   typedef struct packed {
      logic                          kind;
      logic                          ok;
      logic [nnis_pkg::COORD_W-1:0]  x;
      logic [nnis_pkg::PIXEL_W-1:0]  pix;
      logic [AW-1:0]                 addr;
      logic [IDXW-1:0]               idx;
      logic [CW-1:0]                 rx;
      logic [CW-1:0]                 ry;
      logic [Q-1:0]                  qx;
      logic [Q-1:0]                  qy;
   } stage_type;

   // Configuration registers.
   logic [nnis_pkg::DSIZE_W-1:0] dest_width_ff, dest_height_ff, dest_pitch_ff;
   logic [nnis_pkg::SSIZE_W-1:0] source_width_ff, source_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_width_ff <= nnis_pkg::DEST_WIDTH_RST;
         dest_height_ff <= nnis_pkg::DEST_HEIGHT_RST;
         dest_pitch_ff <= nnis_pkg::DEST_PITCH_RST;
         source_width_ff <= nnis_pkg::SOURCE_WIDTH_RST;
         source_height_ff <= nnis_pkg::SOURCE_HEIGHT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            nnis_pkg::REG_DEST_WIDTH: dest_width_ff <= csr_wdata;
            nnis_pkg::REG_DEST_HEIGHT: dest_height_ff <= csr_wdata;
            nnis_pkg::REG_DEST_PITCH: dest_pitch_ff <= csr_wdata;
            nnis_pkg::REG_SOURCE_WIDTH:
               source_width_ff <= csr_wdata[nnis_pkg::SSIZE_W-1:0];
            nnis_pkg::REG_SOURCE_HEIGHT:
               source_height_ff <= csr_wdata[nnis_pkg::SSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective source size, saturated to 1 .. SRC_MAX.
   logic [31:0]    sw_wide, sh_wide;
   logic [SWW-1:0] sw_eff;
   logic [SHW-1:0] sh_eff;

   always_comb begin
      if (source_width_ff == '0) begin
         sw_wide = 32'd1;
      end else if (32'(source_width_ff) > 32'(SRC_MAX_W)) begin
         sw_wide = 32'(SRC_MAX_W);
      end else begin
         sw_wide = 32'(source_width_ff);
      end
      if (source_height_ff == '0) begin
         sh_wide = 32'd1;
      end else if (32'(source_height_ff) > 32'(SRC_MAX_H)) begin
         sh_wide = 32'(SRC_MAX_H);
      end else begin
         sh_wide = 32'(source_height_ff);
      end
      sw_eff = sw_wide[SWW-1:0];
      sh_eff = sh_wide[SHW-1:0];
   end

   // Pipeline registers and handshake.
   stage_type stage_ff [NSTG];
   stage_type stage_in [NSTG];
   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] adv;
   logic            last_leaves;
   logic [nnis_pkg::PIXEL_W-1:0] ram_rd_data;
   logic ram_wr_en, ram_rd_en;

   assign last_leaves = (stage_ff[NSTG-1].kind == nnis_pkg::KIND_LOAD) || rsp_ready;

   // A stage can take a new item when it is empty or its item moves on.
   always_comb begin
      adv[NSTG-1] = !valid_ff[NSTG-1] || last_leaves;
      for (int i = NSTG - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req_ready = adv[0];

   always_comb begin
      logic [nnis_pkg::COORD_W+SWW-1:0] nx;
      logic [nnis_pkg::COORD_W+SHW-1:0] ny;
      logic [31:0] addr32;
      logic [CW-1:0] dx, dy;
      stage_type s;

      for (int i = 0; i < NSTG; i++) begin
         stage_in[i] = '0;
      end

      // Stage 0: capture the transaction.
      stage_in[0].kind = req_kind;
      stage_in[0].x = req_coord_x;
      stage_in[0].ry = CW'(req_coord_y);
      stage_in[0].pix = req_pixel_in;

      // Stage 1: products, range checks and load address.
      s = stage_ff[0];
      nx = s.x * sw_eff;
      ny = s.ry[nnis_pkg::COORD_W-1:0] * sh_eff;
      addr32 = 32'(s.ry[nnis_pkg::COORD_W-1:0]) * 32'(SRC_MAX_W) + 32'(s.x);
      stage_in[1] = s;
      stage_in[1].rx = CW'(nx);
      stage_in[1].ry = CW'(ny);
      stage_in[1].idx = IDXW'(s.ry[nnis_pkg::COORD_W-1:0] * dest_pitch_ff);
      stage_in[1].addr = addr32[AW-1:0];
      if (s.kind == nnis_pkg::KIND_LOAD) begin
         stage_in[1].ok = (32'(s.x) < sw_wide) &&
                          (32'(s.ry[nnis_pkg::COORD_W-1:0]) < sh_wide);
      end else begin
         stage_in[1].ok = (nnis_pkg::DSIZE_W'(s.x) < dest_width_ff) &&
                          (nnis_pkg::DSIZE_W'(s.ry[nnis_pkg::COORD_W-1:0]) <
                           dest_height_ff);
      end

      // Restoring division, one quotient bit per stage, most significant first.
      for (int j = 0; j < Q; j++) begin
         s = stage_ff[1+j];
         stage_in[2+j] = s;
         if (j == 0) begin
            stage_in[2+j].idx = s.idx + IDXW'(s.x);
         end
         dx = CW'(dest_width_ff) << (Q - 1 - j);
         dy = CW'(dest_height_ff) << (Q - 1 - j);
         if (s.rx >= dx) begin
            stage_in[2+j].rx = s.rx - dx;
            stage_in[2+j].qx[Q-1-j] = 1'b1;
         end
         if (s.ry >= dy) begin
            stage_in[2+j].ry = s.ry - dy;
            stage_in[2+j].qy[Q-1-j] = 1'b1;
         end
      end

      // Fetch address from the scaled coordinates.
      s = stage_ff[STG_ADDR-1];
      stage_in[STG_ADDR] = s;
      if (s.kind == nnis_pkg::KIND_FETCH) begin
         addr32 = 32'(s.qy) * 32'(SRC_MAX_W) + 32'(s.qx);
         stage_in[STG_ADDR].addr = addr32[AW-1:0];
      end

      // Result stage; the pixel arrives from the RAM read register.
      stage_in[NSTG-1] = stage_ff[STG_ADDR];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTG; i++) begin
         if (adv[i]) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   // Loads and fetches touch the store in the same stage, so program order holds.
   assign ram_wr_en = valid_ff[STG_ADDR] && adv[STG_ADDR+1] &&
                      (stage_ff[STG_ADDR].kind == nnis_pkg::KIND_LOAD) &&
                      stage_ff[STG_ADDR].ok;
   assign ram_rd_en = valid_ff[STG_ADDR] && adv[STG_ADDR+1] &&
                      (stage_ff[STG_ADDR].kind == nnis_pkg::KIND_FETCH);

   nnis_ram #(
      .WIDTH(nnis_pkg::PIXEL_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(stage_ff[STG_ADDR].addr),
      .wr_data(stage_ff[STG_ADDR].pix),
      .rd_en  (ram_rd_en),
      .rd_addr(stage_ff[STG_ADDR].addr),
      .rd_data(ram_rd_data)
   );

   assign rsp_valid = valid_ff[NSTG-1] && (stage_ff[NSTG-1].kind == nnis_pkg::KIND_FETCH);
   assign rsp_dest_index = stage_ff[NSTG-1].ok ?
                           stage_ff[NSTG-1].idx[nnis_pkg::INDEX_W-1:0] : '0;
   assign rsp_pixel_out = stage_ff[NSTG-1].ok ? ram_rd_data : '0;
   assign rsp_out_of_range = !stage_ff[NSTG-1].ok;

   // The store is never written and read in the same cycle.
   a_ram_one_op: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("store written and read in the same cycle");

   // A stalled result keeps its pixel: no read may disturb the RAM output.
   a_rdata_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(ram_rd_data))
      else $error("read data changed under a stalled result");

   // The scaled column and row never reach the effective source size.
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STG_ADDR-1] && stage_ff[STG_ADDR-1].ok &&
      (stage_ff[STG_ADDR-1].kind == nnis_pkg::KIND_FETCH) |->
      (32'(stage_ff[STG_ADDR-1].qx) < sw_wide) && (32'(stage_ff[STG_ADDR-1].qy) < sh_wide))
      else $error("scaled coordinate outside the source image");

endmodule

>>> hw/rtl/nnis_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module nnis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> tb/tb_nearest_neighbor_image_scaler.sv
// Self-checking testbench for the nearest-neighbor image scaler.
// Depends on nnis_pkg and the nearest_neighbor_image_scaler RTL.
`timescale 1ns / 1ps

module tb_nearest_neighbor_image_scaler;

   localparam int STORE_W = 256;
   localparam int STORE_H = 256;
   localparam int DRAIN_CYCLES = 24;
   // An index past the last configuration register.
   localparam logic [nnis_pkg::CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   typedef struct {
      logic                          kind;
      logic [nnis_pkg::COORD_W-1:0]  x;
      logic [nnis_pkg::COORD_W-1:0]  y;
      logic [nnis_pkg::PIXEL_W-1:0]  pix;
   } pixel_req_type;

   typedef struct {
      logic [nnis_pkg::INDEX_W-1:0]  index;
      logic [nnis_pkg::PIXEL_W-1:0]  pix;
      logic                          oor;
   } scaled_pixel_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic                            req_kind;
   logic [nnis_pkg::COORD_W-1:0]    req_coord_x;
   logic [nnis_pkg::COORD_W-1:0]    req_coord_y;
   logic [nnis_pkg::PIXEL_W-1:0]    req_pixel_in;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [nnis_pkg::INDEX_W-1:0]    rsp_dest_index;
   logic [nnis_pkg::PIXEL_W-1:0]    rsp_pixel_out;
   logic                            rsp_out_of_range;
   logic                            csr_wr_en;
   logic [nnis_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [nnis_pkg::CSR_DATA_W-1:0] csr_wdata;

   pixel_req_type    pending_reqs[$];
   scaled_pixel_type expected_pixels[$];
   int               error_count;
   int               cycle_count;

   // Shadow copy of the pixel store and registers.
   logic [nnis_pkg::PIXEL_W-1:0] shadow_image[STORE_W*STORE_H];
   bit                           loaded[STORE_W*STORE_H];
   int unsigned                  dst_w, dst_h, dst_pitch, src_w, src_h;

   nearest_neighbor_image_scaler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y), .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_dest_index(rsp_dest_index),
      .rsp_pixel_out(rsp_pixel_out), .rsp_out_of_range(rsp_out_of_range),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned eff_size(int unsigned v);
      if (v == 0) return 1;
      if (v > STORE_W) return STORE_W;
      return v;
   endfunction

   // Idling is suppressed during one long window so back-to-back traffic is seen.
   function automatic bit idle_now();
      if (cycle_count >= 400 && cycle_count < 900) return 1'b0;
      return ($urandom_range(0, 99) < 20);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch in %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic csr_write(logic [nnis_pkg::CSR_IDX_W-1:0] idx, int unsigned value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[nnis_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         nnis_pkg::REG_DEST_WIDTH: dst_w = value & 32'h1FFF;
         nnis_pkg::REG_DEST_HEIGHT: dst_h = value & 32'h1FFF;
         nnis_pkg::REG_DEST_PITCH: dst_pitch = value & 32'h1FFF;
         nnis_pkg::REG_SOURCE_WIDTH: src_w = value & 32'h1FF;
         nnis_pkg::REG_SOURCE_HEIGHT: src_h = value & 32'h1FF;
         default: ;
      endcase
   endtask

   task automatic set_geometry(int unsigned dw, int unsigned dh, int unsigned pitch,
                               int unsigned sw, int unsigned sh);
      csr_write(nnis_pkg::REG_DEST_WIDTH, dw);
      csr_write(nnis_pkg::REG_DEST_HEIGHT, dh);
      csr_write(nnis_pkg::REG_DEST_PITCH, pitch);
      csr_write(nnis_pkg::REG_SOURCE_WIDTH, sw);
      csr_write(nnis_pkg::REG_SOURCE_HEIGHT, sh);
   endtask

   task automatic send_load(int unsigned x, int unsigned y,
                            logic [nnis_pkg::PIXEL_W-1:0] pix);
      pixel_req_type r;
      r.kind = nnis_pkg::KIND_LOAD;
      r.x = x[nnis_pkg::COORD_W-1:0];
      r.y = y[nnis_pkg::COORD_W-1:0];
      r.pix = pix;
      if (r.x < eff_size(src_w) && r.y < eff_size(src_h)) begin
         shadow_image[r.y * STORE_W + r.x] = pix;
         loaded[r.y * STORE_W + r.x] = 1'b1;
      end
      pending_reqs.push_back(r);
   endtask

   // Loads the needed source pixel first when it was never written, so that no
   // fetch reads an undefined store entry.
   task automatic send_fetch(int unsigned x, int unsigned y);
      pixel_req_type    r;
      scaled_pixel_type e;
      int unsigned      sx, sy;
      longint unsigned  idx;
      r.kind = nnis_pkg::KIND_FETCH;
      r.x = x[nnis_pkg::COORD_W-1:0];
      r.y = y[nnis_pkg::COORD_W-1:0];
      r.pix = $urandom();
      if (r.x >= dst_w || r.y >= dst_h) begin
         e.index = '0;
         e.pix = '0;
         e.oor = 1'b1;
      end else begin
         sx = (longint'(r.x) * eff_size(src_w)) / dst_w;
         sy = (longint'(r.y) * eff_size(src_h)) / dst_h;
         if (!loaded[sy * STORE_W + sx]) send_load(sx, sy, $urandom());
         idx = longint'(r.y) * dst_pitch + r.x;
         e.index = idx[nnis_pkg::INDEX_W-1:0];
         e.pix = shadow_image[sy * STORE_W + sx];
         e.oor = 1'b0;
      end
      pending_reqs.push_back(r);
      expected_pixels.push_back(e);
   endtask

   task automatic random_traffic(int n);
      int unsigned sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 30)
            send_load($urandom_range(0, eff_size(src_w) - 1),
                      $urandom_range(0, eff_size(src_h) - 1), $urandom());
         else if (sel < 38)
            send_load($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom());
         else if (sel < 88 && dst_w > 0 && dst_h > 0)
            send_fetch($urandom_range(0, (dst_w > 4096 ? 4096 : dst_w) - 1),
                       $urandom_range(0, (dst_h > 4096 ? 4096 : dst_h) - 1));
         else
            send_fetch($urandom_range(0, 4095), $urandom_range(0, 4095));
      end
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) void'(pending_reqs.pop_front());
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && !idle_now()) begin
               req_valid <= 1'b1;
               req_kind <= pending_reqs[0].kind;
               req_coord_x <= pending_reqs[0].x;
               req_coord_y <= pending_reqs[0].y;
               req_pixel_in <= pending_reqs[0].pix;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor and result stall
   always @(posedge clock) begin
      scaled_pixel_type e;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idle_now();
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected result transaction", 1, 0);
            end else begin
               e = expected_pixels.pop_front();
               if (rsp_dest_index !== e.index)
                  report_mismatch("dest_index", rsp_dest_index, e.index);
               if (rsp_pixel_out !== e.pix)
                  report_mismatch("pixel_out", rsp_pixel_out, e.pix);
               if (rsp_out_of_range !== e.oor)
                  report_mismatch("out_of_range", rsp_out_of_range, e.oor);
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      error_count = 0;
      cycle_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = nnis_pkg::KIND_LOAD;
      req_coord_x = '0;
      req_coord_y = '0;
      req_pixel_in = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      dst_w = nnis_pkg::DEST_WIDTH_RST;
      dst_h = nnis_pkg::DEST_HEIGHT_RST;
      dst_pitch = nnis_pkg::DEST_PITCH_RST;
      src_w = nnis_pkg::SOURCE_WIDTH_RST;
      src_h = nnis_pkg::SOURCE_HEIGHT_RST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed checks at the reset geometry.
      send_load(0, 0, 32'hFFFF_FFFF);
      send_load(255, 255, 32'h0000_0000);
      send_load(256, 0, 32'hDEAD_BEEF);
      send_load(0, 256, 32'hDEAD_BEEF);
      send_load(4095, 4095, 32'hA5A5_5A5A);
      send_fetch(0, 0);
      send_fetch(1023, 767);
      send_fetch(1024, 0);
      send_fetch(0, 768);
      send_fetch(4095, 4095);
      send_fetch(512, 384);
      random_traffic(100);
      wait_idle();

      // Largest destination: the index fills all 24 bits.
      set_geometry(4096, 4096, 4096, 256, 256);
      send_fetch(4095, 4095);
      send_fetch(4095, 0);
      send_fetch(0, 4095);
      random_traffic(100);
      wait_idle();

      // Smallest geometry everywhere.
      set_geometry(1, 1, 1, 1, 1);
      send_fetch(0, 0);
      send_fetch(1, 0);
      send_fetch(0, 1);
      random_traffic(80);
      wait_idle();

      // Source sizes out of range saturate; the stored image keeps its layout.
      set_geometry(640, 480, 700, 0, 13'h1FFF);
      random_traffic(100);
      wait_idle();

      // A zero destination height makes every fetch out of range.
      set_geometry(100, 0, 100, 50, 50);
      send_fetch(0, 0);
      random_traffic(40);
      wait_idle();

      // An index beyond the register list must change nothing.
      set_geometry(37, 23, 4096, 200, 17);
      csr_write(REG_UNMAPPED, 13'h1FFF);
      random_traffic(120);
      wait_idle();

      set_geometry(16, 16, 16, 8, 8);
      random_traffic(100);
      wait_idle();

      set_geometry($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 4096),
                   $urandom_range(1, 256), $urandom_range(1, 256));
      random_traffic(120);
      wait_idle();

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/nnis_pkg.sv
hw/rtl/nnis_ram.sv
hw/rtl/nearest_neighbor_image_scaler.sv
tb/tb_nearest_neighbor_image_scaler.sv
